### sv/interval_set_merge_lookup_assert.svh
// ----------------------------------------------------------------------------
// Interval set assertion macros
// Concurrent assertion forms used by the interval set datapath.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_SET_MERGE_LOOKUP_ASSERT_SVH
`define INTERVAL_SET_MERGE_LOOKUP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISML_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISML_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### sv/isml_pkg.sv
// ----------------------------------------------------------------------------
// Interval set package
// Sizes, codes and the command and status bundles shared by the modules.
// ----------------------------------------------------------------------------
package isml_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int VALUE_BITS  = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_REVERSED = 2'd1,
    STATUS_FULL     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_PROC,
    ST_FINISH,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic proc;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic empty;
    logic last;
    logic full_now;
  } stat_t;

endpackage

### sv/isml_datapath.sv
// ----------------------------------------------------------------------------
// Interval set datapath
// Range table memory, scan registers, merge logic and result registers.
// ----------------------------------------------------------------------------
`include "interval_set_merge_lookup_assert.svh"

module isml_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  isml_pkg::cmd_t                 cmd,
  output isml_pkg::stat_t                stat,
  input  logic                           in_kind,
  input  logic [isml_pkg::VALUE_BITS-1:0] in_low_value,
  input  logic [isml_pkg::VALUE_BITS-1:0] in_high_value,
  output logic [1:0]                     out_status,
  output logic                           out_is_member,
  output logic                           out_upper_found,
  output logic [isml_pkg::VALUE_BITS-1:0] out_next_upper,
  output logic                           out_lower_found,
  output logic [isml_pkg::VALUE_BITS-1:0] out_next_lower
);

  localparam int VB = isml_pkg::VALUE_BITS;
  localparam int IW = isml_pkg::IDX_W;
  localparam int CW = isml_pkg::CNT_W;

  logic [VB-1:0] mem_lo [isml_pkg::TABLE_DEPTH];
  logic [VB-1:0] mem_hi [isml_pkg::TABLE_DEPTH];

  logic [VB-1:0] rd_lo_r, rd_hi_r;

  logic             op_r, op_nxt;
  logic [VB-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic [VB-1:0]    lo_m1_r, lo_m1_nxt, hi_p1_r, hi_p1_nxt;
  logic [IW-1:0]    k_r, k_nxt;
  logic [CW-1:0]    wr_r, wr_nxt, count_r, count_nxt;
  logic             placed_r, placed_nxt;
  logic [VB-1:0]    carry_lo_r, carry_lo_nxt, carry_hi_r, carry_hi_nxt;
  isml_pkg::status_t status_r, status_nxt;
  logic             member_r, member_nxt;
  logic             upper_found_r, upper_found_nxt;
  logic [VB-1:0]    next_upper_r, next_upper_nxt;
  logic             lower_found_r, lower_found_nxt;
  logic [VB-1:0]    next_lower_r, next_lower_nxt;

  logic          we;
  logic [VB-1:0] wdata_lo, wdata_hi;
  logic          below, touch_new, touch_carry, table_full;
  logic [VB-1:0] carry_inc;

  assign below       = rd_hi_r < lo_m1_r;
  assign touch_new   = hi_p1_r >= rd_lo_r;
  assign carry_inc   = (carry_hi_r == isml_pkg::VALUE_MAX) ? isml_pkg::VALUE_MAX
                                                           : carry_hi_r + VB'(1);
  assign touch_carry = rd_lo_r <= carry_inc;
  assign table_full  = count_r == CW'(isml_pkg::TABLE_DEPTH);

  assign stat.reject   = status_r != isml_pkg::STATUS_OK;
  assign stat.empty    = count_r == CW'(0);
  assign stat.last     = (CW'(k_r) + CW'(1)) == count_r;
  assign stat.full_now = (op_r == isml_pkg::KIND_INSERT) && !placed_r && !below &&
                         !touch_new && table_full;

  always_comb begin
    op_nxt          = op_r;
    a_nxt           = a_r;
    b_nxt           = b_r;
    lo_m1_nxt       = lo_m1_r;
    hi_p1_nxt       = hi_p1_r;
    k_nxt           = k_r;
    wr_nxt          = wr_r;
    count_nxt       = count_r;
    placed_nxt      = placed_r;
    carry_lo_nxt    = carry_lo_r;
    carry_hi_nxt    = carry_hi_r;
    status_nxt      = status_r;
    member_nxt      = member_r;
    upper_found_nxt = upper_found_r;
    next_upper_nxt  = next_upper_r;
    lower_found_nxt = lower_found_r;
    next_lower_nxt  = next_lower_r;
    we              = 1'b0;
    wdata_lo        = a_r;
    wdata_hi        = b_r;

    if (cmd.load) begin
      op_nxt          = in_kind;
      a_nxt           = in_low_value;
      b_nxt           = in_high_value;
      lo_m1_nxt       = (in_low_value == VB'(0)) ? VB'(0) : in_low_value - VB'(1);
      hi_p1_nxt       = (in_high_value == isml_pkg::VALUE_MAX) ? isml_pkg::VALUE_MAX
                                                               : in_high_value + VB'(1);
      k_nxt           = IW'(0);
      wr_nxt          = CW'(0);
      placed_nxt      = 1'b0;
      status_nxt      = ((in_kind == isml_pkg::KIND_INSERT) &&
                         (in_low_value > in_high_value)) ? isml_pkg::STATUS_REVERSED
                                                         : isml_pkg::STATUS_OK;
      member_nxt      = 1'b0;
      upper_found_nxt = 1'b0;
      next_upper_nxt  = VB'(0);
      lower_found_nxt = 1'b0;
      next_lower_nxt  = VB'(0);
    end else if (cmd.proc) begin
      k_nxt = k_r + IW'(1);
      if (op_r == isml_pkg::KIND_QUERY) begin
        if (!upper_found_r && (rd_hi_r >= a_r)) begin
          upper_found_nxt = 1'b1;
          next_upper_nxt  = rd_hi_r;
          member_nxt      = rd_lo_r <= a_r;
        end
        if (!lower_found_r && (rd_lo_r >= a_r)) begin
          lower_found_nxt = 1'b1;
          next_lower_nxt  = rd_lo_r;
        end
      end else if (!placed_r) begin
        if (below) begin
          wr_nxt = wr_r + CW'(1);
        end else if (touch_new) begin
          carry_lo_nxt = (a_r < rd_lo_r) ? a_r : rd_lo_r;
          carry_hi_nxt = (b_r > rd_hi_r) ? b_r : rd_hi_r;
          placed_nxt   = 1'b1;
        end else if (table_full) begin
          status_nxt = isml_pkg::STATUS_FULL;
        end else begin
          we           = 1'b1;
          wr_nxt       = wr_r + CW'(1);
          carry_lo_nxt = rd_lo_r;
          carry_hi_nxt = rd_hi_r;
          placed_nxt   = 1'b1;
        end
      end else if (touch_carry) begin
        carry_hi_nxt = (rd_hi_r > carry_hi_r) ? rd_hi_r : carry_hi_r;
      end else begin
        we           = 1'b1;
        wdata_lo     = carry_lo_r;
        wdata_hi     = carry_hi_r;
        wr_nxt       = wr_r + CW'(1);
        carry_lo_nxt = rd_lo_r;
        carry_hi_nxt = rd_hi_r;
      end
    end else if (cmd.fin && (op_r == isml_pkg::KIND_INSERT)) begin
      if (placed_r) begin
        we        = 1'b1;
        wdata_lo  = carry_lo_r;
        wdata_hi  = carry_hi_r;
        count_nxt = wr_r + CW'(1);
      end else if (table_full) begin
        status_nxt = isml_pkg::STATUS_FULL;
      end else begin
        we        = 1'b1;
        count_nxt = wr_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= CW'(0);
      wr_r     <= CW'(0);
      k_r      <= IW'(0);
      placed_r <= 1'b0;
      status_r <= isml_pkg::STATUS_OK;
    end else begin
      count_r  <= count_nxt;
      wr_r     <= wr_nxt;
      k_r      <= k_nxt;
      placed_r <= placed_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    a_r           <= a_nxt;
    b_r           <= b_nxt;
    lo_m1_r       <= lo_m1_nxt;
    hi_p1_r       <= hi_p1_nxt;
    carry_lo_r    <= carry_lo_nxt;
    carry_hi_r    <= carry_hi_nxt;
    member_r      <= member_nxt;
    upper_found_r <= upper_found_nxt;
    next_upper_r  <= next_upper_nxt;
    lower_found_r <= lower_found_nxt;
    next_lower_r  <= next_lower_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_lo[wr_r[IW-1:0]] <= wdata_lo;
      mem_hi[wr_r[IW-1:0]] <= wdata_hi;
    end
    if (cmd.rd) begin
      rd_lo_r <= mem_lo[k_r];
      rd_hi_r <= mem_hi[k_r];
    end
  end

  assign out_status      = status_r;
  assign out_is_member   = member_r;
  assign out_upper_found = upper_found_r;
  assign out_next_upper  = next_upper_r;
  assign out_lower_found = lower_found_r;
  assign out_next_lower  = next_lower_r;

  `ISML_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1,
    count_r <= CW'(isml_pkg::TABLE_DEPTH), "Range count exceeds the table depth.")
  `ISML_ASSERT_NOW(a_wr_bound, clk, rst_n, 1'b1,
    wr_r <= count_r, "Write pointer ran past the stored range count.")
  `ISML_ASSERT_NEXT(a_count_hold, clk, rst_n, !cmd.fin,
    $stable(count_r), "Range count changed outside the finish step.")

endmodule

### sv/isml_ctrl.sv
// ----------------------------------------------------------------------------
// Interval set controller
// Sequences the load, check, table scan, finish and result steps of one beat.
// ----------------------------------------------------------------------------
module isml_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output logic            out_valid,
  output isml_pkg::cmd_t  cmd,
  input  isml_pkg::stat_t stat
);

  isml_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isml_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      isml_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = isml_pkg::ST_CHECK;
        end
      end
      isml_pkg::ST_CHECK: begin
        if (stat.reject) begin
          state_nxt = isml_pkg::ST_RESULT;
        end else if (stat.empty) begin
          state_nxt = isml_pkg::ST_FINISH;
        end else begin
          state_nxt = isml_pkg::ST_READ;
        end
      end
      isml_pkg::ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = isml_pkg::ST_PROC;
      end
      isml_pkg::ST_PROC: begin
        cmd.proc = 1'b1;
        if (stat.full_now) begin
          state_nxt = isml_pkg::ST_RESULT;
        end else if (stat.last) begin
          state_nxt = isml_pkg::ST_FINISH;
        end else begin
          state_nxt = isml_pkg::ST_READ;
        end
      end
      isml_pkg::ST_FINISH: begin
        cmd.fin   = 1'b1;
        state_nxt = isml_pkg::ST_RESULT;
      end
      isml_pkg::ST_RESULT: begin
        out_valid = 1'b1;
        state_nxt = isml_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = isml_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### sv/interval_set_merge_lookup.sv
// ----------------------------------------------------------------------------
// Interval set merge and lookup
// Sorted table of disjoint ranges with merging insert and boundary query.
// ----------------------------------------------------------------------------
// A beat is accepted when start is high and busy is low. in_kind selects an
// insert of [in_low_value, in_high_value] or a query of in_low_value.
// Every beat produces exactly one result, shown for a single cycle with
// out_valid high; the receiver cannot stall it and must take it then.
// The table of up to 16 ranges sits in a one-port-write, one-port-read
// memory, and the controller scans it one entry at a time (read, then
// compare and merge or shift). The result strobe follows the check step,
// the scan of the stored ranges and the finish step; busy stays high
// through the strobe cycle, so the next beat is taken only after it. A
// reversed insert skips the scan and the finish step and goes straight
// to the result. An insert refused for a full table may end its scan
// early. Merged and shifted entries are written back in place during the
// same scan. Synchronous reset empties the table and returns to idle; the
// table memory itself is not cleared, since entries past the count are
// never read.
// ----------------------------------------------------------------------------
module interval_set_merge_lookup (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_kind,
  input  logic [isml_pkg::VALUE_BITS-1:0] in_low_value,
  input  logic [isml_pkg::VALUE_BITS-1:0] in_high_value,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic                            out_is_member,
  output logic                            out_upper_found,
  output logic [isml_pkg::VALUE_BITS-1:0] out_next_upper,
  output logic                            out_lower_found,
  output logic [isml_pkg::VALUE_BITS-1:0] out_next_lower
);

  isml_pkg::cmd_t  cmd;
  isml_pkg::stat_t stat;

  isml_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  isml_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_low_value    (in_low_value),
    .in_high_value   (in_high_value),
    .out_status      (out_status),
    .out_is_member   (out_is_member),
    .out_upper_found (out_upper_found),
    .out_next_upper  (out_next_upper),
    .out_lower_found (out_lower_found),
    .out_next_lower  (out_next_lower)
  );

endmodule

### tb/interval_set_merge_lookup_test.sv
// ----------------------------------------------------------------------------
// Interval set merge and lookup testbench
// Drives insert and query beats through the start and busy handshake and
// predicts every result with an independent copy of the range table. Each
// strobed result is compared field by field with the oldest prediction.
// Directed tests cover the empty table, reversed ranges, saturation at both
// ends of the value space, a full table and merges while full. Random
// episodes then grow ranges inside moving windows of the value space.
// ----------------------------------------------------------------------------
module interval_set_merge_lookup_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VB = isml_pkg::VALUE_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BEATS = 850;

  typedef struct packed {
    isml_pkg::status_t status;
    logic              is_member;
    logic              upper_found;
    logic [VB-1:0]     next_upper;
    logic              lower_found;
    logic [VB-1:0]     next_lower;
  } result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic          in_kind = isml_pkg::KIND_INSERT;
  logic [VB-1:0] in_low_value = '0;
  logic [VB-1:0] in_high_value = '0;
  logic          out_valid;
  logic [1:0]    out_status;
  logic          out_is_member;
  logic          out_upper_found;
  logic [VB-1:0] out_next_upper;
  logic          out_lower_found;
  logic [VB-1:0] out_next_lower;

  logic [VB-1:0] table_lows [isml_pkg::TABLE_DEPTH];
  logic [VB-1:0] table_highs[isml_pkg::TABLE_DEPTH];
  int            table_count = 0;

  result_t predicted_results[$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  bit      steady_feed = 1'b0;

  interval_set_merge_lookup u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_low_value   (in_low_value),
    .in_high_value  (in_high_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_is_member  (out_is_member),
    .out_upper_found(out_upper_found),
    .out_next_upper (out_next_upper),
    .out_lower_found(out_lower_found),
    .out_next_lower (out_next_lower)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [VB-1:0] step_up(input logic [VB-1:0] v);
    return (v == isml_pkg::VALUE_MAX) ? v : v + 1'b1;
  endfunction

  // Applies one beat to the table copy and returns the result it must produce.
  function automatic result_t predict_table_result(input logic kind,
                                                   input logic [VB-1:0] a,
                                                   input logic [VB-1:0] b);
    result_t       r;
    logic [VB-1:0] lo_m1;
    logic [VB-1:0] hi_p1;
    int            i;
    int            j;
    int            k;
    r.status = isml_pkg::STATUS_OK;
    r.is_member = 1'b0;
    r.upper_found = 1'b0;
    r.next_upper = '0;
    r.lower_found = 1'b0;
    r.next_lower = '0;
    if (kind == isml_pkg::KIND_QUERY) begin
      i = 0;
      while (i < table_count && table_highs[i] < a) i++;
      if (i < table_count) begin
        r.is_member = (a >= table_lows[i]);
        r.upper_found = 1'b1;
        r.next_upper = table_highs[i];
      end
      i = 0;
      while (i < table_count && table_lows[i] < a) i++;
      if (i < table_count) begin
        r.lower_found = 1'b1;
        r.next_lower = table_lows[i];
      end
    end else if (a > b) begin
      r.status = isml_pkg::STATUS_REVERSED;
    end else begin
      lo_m1 = (a == '0) ? a : a - 1'b1;
      hi_p1 = step_up(b);
      i = 0;
      while (i < table_count && table_highs[i] < lo_m1) i++;
      if (i < table_count && hi_p1 >= table_lows[i]) begin
        if (a < table_lows[i]) table_lows[i] = a;
        if (b > table_highs[i]) table_highs[i] = b;
        j = 0;
        while (j + 1 < table_count) begin
          if (table_lows[j+1] <= step_up(table_highs[j])) begin
            if (table_highs[j+1] > table_highs[j]) table_highs[j] = table_highs[j+1];
            for (k = j + 1; k + 1 < table_count; k++) begin
              table_lows[k] = table_lows[k+1];
              table_highs[k] = table_highs[k+1];
            end
            table_count--;
          end else begin
            j++;
          end
        end
      end else if (table_count >= isml_pkg::TABLE_DEPTH) begin
        r.status = isml_pkg::STATUS_FULL;
      end else begin
        for (k = table_count; k > i; k--) begin
          table_lows[k] = table_lows[k-1];
          table_highs[k] = table_highs[k-1];
        end
        table_lows[i] = a;
        table_highs[i] = b;
        table_count++;
      end
    end
    return r;
  endfunction

  task automatic send_beat(input logic kind, input logic [VB-1:0] a,
                           input logic [VB-1:0] b);
    int      gap;
    result_t want;
    gap = steady_feed ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_low_value <= a;
    in_high_value <= b;
    do @(posedge clk); while (busy);
    want = predict_table_result(kind, a, b);
    predicted_results = {predicted_results, want};
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid) begin
      if (predicted_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status=%0d member=%0b upper=%0b/%h lower=%0b/%h",
                   out_status, out_is_member, out_upper_found, out_next_upper,
                   out_lower_found, out_next_lower);
      end else begin
        want = predicted_results.pop_front();
        if (out_status !== want.status || out_is_member !== want.is_member ||
            out_upper_found !== want.upper_found || out_next_upper !== want.next_upper ||
            out_lower_found !== want.lower_found || out_next_lower !== want.next_lower) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected status=%0d member=%0b upper=%0b/%h lower=%0b/%h",
                     want.status, want.is_member, want.upper_found, want.next_upper,
                     want.lower_found, want.next_lower);
            $display("          actual   status=%0d member=%0b upper=%0b/%h lower=%0b/%h",
                     out_status, out_is_member, out_upper_found, out_next_upper,
                     out_lower_found, out_next_lower);
          end
        end
      end
    end
  end

  task automatic test_empty_and_reversed();
    send_beat(isml_pkg::KIND_QUERY, '0, isml_pkg::VALUE_MAX);
    send_beat(isml_pkg::KIND_INSERT, 32'd1, 32'd0);
    send_beat(isml_pkg::KIND_INSERT, isml_pkg::VALUE_MAX, '0);
  endtask

  task automatic test_edge_saturation();
    send_beat(isml_pkg::KIND_INSERT, '0, '0);
    send_beat(isml_pkg::KIND_INSERT, isml_pkg::VALUE_MAX, isml_pkg::VALUE_MAX);
    send_beat(isml_pkg::KIND_INSERT, 32'd2, 32'd2);
    send_beat(isml_pkg::KIND_INSERT, 32'd1, 32'd1);
    send_beat(isml_pkg::KIND_QUERY, 32'd1, '0);
    send_beat(isml_pkg::KIND_QUERY, isml_pkg::VALUE_MAX, isml_pkg::VALUE_MAX);
  endtask

  task automatic test_full_table();
    logic [VB-1:0] top_bits;
    steady_feed = 1'b1;
    for (int k = 1; k <= 14; k++) begin
      top_bits = k << 28;
      send_beat(isml_pkg::KIND_INSERT, top_bits | 32'h100, top_bits | 32'h1ff);
    end
    steady_feed = 1'b0;
    // The table is full now, so a fresh range is refused but merges still go in.
    send_beat(isml_pkg::KIND_INSERT, 32'hf000_0000, 32'hf000_0010);
    send_beat(isml_pkg::KIND_INSERT, 32'h1000_0200, 32'h1000_0300);
    send_beat(isml_pkg::KIND_INSERT, 32'h2000_0200, 32'h3000_00ff);
    send_beat(isml_pkg::KIND_QUERY, 32'h3000_0000, 32'h5555_aaaa);
  endtask

  task automatic test_random_sequences();
    logic [VB-1:0] window_lo;
    logic [VB-1:0] window_hi;
    logic [VB-1:0] span;
    logic [VB-1:0] lo;
    logic [VB-1:0] hi;
    logic [VB-1:0] v;
    int            sent;
    int            pick;
    int            idx;
    bit            at_top;
    sent = 0;
    at_top = 1'b0;
    window_lo = 32'h0000_4000;
    while (sent < RANDOM_BEATS) begin
      steady_feed = ($urandom_range(0, 3) == 0);
      span = 32'd1 << $urandom_range(6, 20);
      if (sent >= RANDOM_BEATS - 70) begin
        at_top = 1'b1;
        window_lo = isml_pkg::VALUE_MAX - span;
      end
      window_hi = window_lo + span;
      // Folding everything below the window into one range frees slots.
      if ($urandom_range(0, 3) != 0) begin
        send_beat(isml_pkg::KIND_INSERT, '0, window_lo - 1'b1);
        sent++;
      end
      repeat ($urandom_range(20, 50)) begin
        pick = $urandom_range(0, 99);
        idx = (table_count > 0) ? $urandom_range(0, table_count - 1) : 0;
        if (pick < 45) begin
          lo = window_lo + $urandom_range(0, span);
          hi = lo + $urandom_range(0, span >> $urandom_range(2, 8));
          if (hi > window_hi || hi < lo) hi = window_hi;
          send_beat(isml_pkg::KIND_INSERT, lo, hi);
        end else if (pick < 58 && table_count > 0) begin
          case ($urandom_range(0, 2))
            0: begin
              lo = step_up(table_highs[idx]);
              hi = lo + $urandom_range(0, 15);
              if (hi < lo) hi = isml_pkg::VALUE_MAX;
            end
            1: begin
              hi = (table_lows[idx] == '0) ? '0 : table_lows[idx] - 1'b1;
              lo = hi - $urandom_range(0, 15);
              if (lo > hi) lo = '0;
            end
            default: begin
              lo = step_up(table_highs[idx]);
              hi = (idx + 1 < table_count) ? table_lows[idx+1] - 1'b1
                                           : isml_pkg::VALUE_MAX;
            end
          endcase
          send_beat(isml_pkg::KIND_INSERT, lo, hi);
        end else if (pick < 85) begin
          if (table_count > 0 && $urandom_range(0, 1)) begin
            v = $urandom_range(0, 1) ? table_lows[idx] : table_highs[idx];
            v = v + $urandom_range(0, 2) - 1;
          end else begin
            v = window_lo - 4 + $urandom_range(0, span + 8);
          end
          send_beat(isml_pkg::KIND_QUERY, v, $urandom());
        end else if (pick < 93) begin
          send_beat(isml_pkg::KIND_QUERY, $urandom(), $urandom());
        end else begin
          lo = $urandom();
          hi = $urandom();
          if (lo == hi) hi = lo + 1'b1;
          send_beat(isml_pkg::KIND_INSERT, (lo > hi) ? lo : hi, (lo > hi) ? hi : lo);
        end
        sent++;
      end
      if (at_top) break;
      window_lo = window_hi + $urandom_range(2, 32'h0400_0000);
    end
    steady_feed = 1'b0;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("interval_set_merge_lookup_test: errors");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_reversed();
    test_edge_saturation();
    test_full_table();
    test_random_sequences();
    start <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && predicted_results.size() == 0)
      $display("interval_set_merge_lookup_test: clean");
    else
      $display("interval_set_merge_lookup_test: errors");
    $finish;
  end

endmodule
